// ===== rtl/two_pattern_stream_search_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef TWO_PATTERN_STREAM_SEARCH_TOP_MACROS_SVH
`define TWO_PATTERN_STREAM_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TPSS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tpss check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is held.
`define TPSS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tpss check failed: next-cycle rule");

`endif

// ===== rtl/tpss_pkg.sv =====
`timescale 1ns / 1ps

package tpss_pkg;

    // Configuration port geometry and register map.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_EXACT_CMP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PATTERN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LENGTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_PATTERN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LENGTH  = 3'd5;

    localparam int LENGTH_W = 4;
    localparam int PATTERN_W = 64;
    localparam int OFFSET_W = 32;

    // Bytes counted after the first match saturate at this value.
    localparam logic [3:0] SINCE_MAX = 4'd15;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic                first_found;
        logic [OFFSET_W-1:0] first_offset;
        logic                second_found;
        logic [OFFSET_W-1:0] second_offset;
    } out_item_t;

    // ASCII fold: a..z go to A..Z unless exact compare is selected.
    function automatic logic [7:0] fold(input logic [7:0] c, input logic exact);
        logic [7:0] r;
        r = c;
        if (!exact && c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== rtl/two_pattern_stream_search_top.sv =====
`timescale 1ns / 1ps

// Two-pattern stream search. Stream bytes arrive one item per cycle on the s_ channel while
// s_ready is high, the final byte of a stream marked by last_byte. The block finds the first
// match of the first pattern, then the first match of the second pattern starting at or after
// the end of that match, and returns one result item per stream on the m_ channel (when the
// second pattern hits, on the byte that ends the first match if the second length is zero, or
// on the last byte). Sustained rate is one byte per cycle unless a result meets a full output
// register: both window compares and the state update are combinational in the evaluate stage.
// A result item passes the input register and the evaluate stage into the output register,
// where it can wait for m_ready while further bytes are taken. Offsets are base_offset plus
// the byte position, mod 2^32. After a result, bytes are dropped until the one marked last,
// which rearms the search. Write configuration only while no item is in flight.
module two_pattern_stream_search_top #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [tpss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpss_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    // byte stream in
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tpss_pkg::in_item_t                  s_data,
    // result out
    output logic                                m_valid,
    input  logic                                m_ready,
    output tpss_pkg::out_item_t                 m_data
);

    // Length values 0..MAX_PATTERN.
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    // History bytes behind the current one; at least one so the vector exists.
    localparam int HIST  = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_DONE
    } phase_t;

    // configuration registers
    logic                               exact_cmp_reg;
    logic [tpss_pkg::OFFSET_W-1:0]      base_offset_reg;
    logic [tpss_pkg::PATTERN_W-1:0]     first_pattern_reg;
    logic [tpss_pkg::LENGTH_W-1:0]      first_length_reg;
    logic [tpss_pkg::PATTERN_W-1:0]     second_pattern_reg;
    logic [tpss_pkg::LENGTH_W-1:0]      second_length_reg;

    // input stage
    logic                               in_valid_reg, in_valid_next;
    tpss_pkg::in_item_t                 in_item_reg;

    // search state
    logic [8*HIST-1:0]                  recent_reg, recent_next;
    logic [tpss_pkg::OFFSET_W-1:0]      pos_reg, pos_next;
    phase_t                             phase_reg, phase_next;
    logic [3:0]                         since_reg, since_next;
    logic [tpss_pkg::OFFSET_W-1:0]      first_off_reg, first_off_next;
    logic [LEN_W-1:0]                   fill_reg, fill_next;

    // output stage
    logic                               out_valid_reg, out_valid_next;
    tpss_pkg::out_item_t                out_item_reg, out_item_next;

    logic [LEN_W-1:0]                   len1, len2;
    logic [8*MAX_PATTERN-1:0]           window;
    logic                               hit1, hit2;
    logic                               emit;
    logic                               advance;

    // Effective lengths: first is 1..MAX, second 0..MAX; too large means MAX.
    always_comb begin
        if (first_length_reg == '0) begin
            len1 = LEN_W'(1);
        end else if (first_length_reg > tpss_pkg::LENGTH_W'(MAX_PATTERN)) begin
            len1 = LEN_W'(MAX_PATTERN);
        end else begin
            len1 = LEN_W'(first_length_reg);
        end
        if (second_length_reg > tpss_pkg::LENGTH_W'(MAX_PATTERN)) begin
            len2 = LEN_W'(MAX_PATTERN);
        end else begin
            len2 = LEN_W'(second_length_reg);
        end
    end

    // Window: current byte at the bottom, older bytes above it.
    assign window = (8*MAX_PATTERN)'({recent_reg, in_item_reg.data_byte});

    tpss_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_match_first (
        .pattern    (first_pattern_reg),
        .len        (len1),
        .window     (window),
        .exact      (exact_cmp_reg),
        .hit        (hit1)
    );

    tpss_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_match_second (
        .pattern    (second_pattern_reg),
        .len        (len2),
        .window     (window),
        .exact      (exact_cmp_reg),
        .hit        (hit2)
    );

    // Evaluate the byte held in the input stage against the current state.
    always_comb begin
        logic [3:0]                    since_inc;
        logic                          second_hit;
        logic [tpss_pkg::OFFSET_W-1:0] second_at;
        logic                          found1;

        recent_next    = recent_reg;
        pos_next       = pos_reg;
        phase_next     = phase_reg;
        since_next     = since_reg;
        first_off_next = first_off_reg;
        fill_next      = fill_reg;
        emit           = 1'b0;
        second_hit     = 1'b0;
        second_at      = '0;
        since_inc      = (since_reg < tpss_pkg::SINCE_MAX) ? since_reg + 4'd1 : since_reg;

        case (phase_reg)
            PH_FIRST: begin
                // need enough bytes seen to fill the pattern
                if ((LEN_W+1)'(fill_reg) + (LEN_W+1)'(1) >= (LEN_W+1)'(len1) && hit1) begin
                    first_off_next = base_offset_reg + pos_reg
                                   - (tpss_pkg::OFFSET_W'(len1) - 32'd1);
                    since_next = 4'd0;
                    if (len2 == '0) begin
                        emit       = 1'b1;
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_SECOND;
                    end
                end
            end
            PH_SECOND: begin
                since_next = since_inc;
                if (len2 == '0) begin
                    // second length cleared while searching: end with no second match
                    emit       = 1'b1;
                    phase_next = PH_DONE;
                end else if (since_inc >= 4'(len2) && hit2) begin
                    second_hit = 1'b1;
                    second_at  = base_offset_reg + pos_reg
                               - (tpss_pkg::OFFSET_W'(len2) - 32'd1);
                    emit       = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            default: begin
                // search over: bytes ignored until the last one
            end
        endcase

        // Window and position advance for every byte seen while searching.
        if (phase_reg != PH_DONE) begin
            recent_next = (8*HIST)'({recent_reg, in_item_reg.data_byte});
            if (fill_reg < LEN_W'(MAX_PATTERN - 1)) begin
                fill_next = fill_reg + LEN_W'(1);
            end
            pos_next = pos_reg + 32'd1;
        end

        if (in_item_reg.last_byte && phase_next != PH_DONE) begin
            emit = 1'b1;
        end

        found1 = (phase_next != PH_FIRST);
        out_item_next.first_found   = found1;
        out_item_next.first_offset  = found1 ? first_off_next : '0;
        out_item_next.second_found  = second_hit;
        out_item_next.second_offset = second_at;

        if (emit) begin
            phase_next = PH_DONE;
        end

        // End of stream rearms the search.
        if (in_item_reg.last_byte) begin
            recent_next    = '0;
            pos_next       = '0;
            phase_next     = PH_FIRST;
            since_next     = '0;
            first_off_next = '0;
            fill_next      = '0;
        end
    end

    // The byte moves on unless it makes a result and the output slot stays full.
    assign advance = in_valid_reg && (!emit || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance && emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exact_cmp_reg      <= 1'b1;
            base_offset_reg    <= '0;
            first_pattern_reg  <= '0;
            first_length_reg   <= tpss_pkg::LENGTH_W'(1);
            second_pattern_reg <= '0;
            second_length_reg  <= tpss_pkg::LENGTH_W'(1);
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            recent_reg         <= '0;
            pos_reg            <= '0;
            phase_reg          <= PH_FIRST;
            since_reg          <= '0;
            first_off_reg      <= '0;
            fill_reg           <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    tpss_pkg::CFG_EXACT_CMP:      exact_cmp_reg      <= cfg_wr_data[0];
                    tpss_pkg::CFG_BASE_OFFSET:    base_offset_reg    <= cfg_wr_data[31:0];
                    tpss_pkg::CFG_FIRST_PATTERN:  first_pattern_reg  <= cfg_wr_data;
                    tpss_pkg::CFG_FIRST_LENGTH:   first_length_reg   <= cfg_wr_data[3:0];
                    tpss_pkg::CFG_SECOND_PATTERN: second_pattern_reg <= cfg_wr_data;
                    tpss_pkg::CFG_SECOND_LENGTH:  second_length_reg  <= cfg_wr_data[3:0];
                    default: begin
                        // unmapped index: write dropped
                    end
                endcase
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                recent_reg    <= recent_next;
                pos_reg       <= pos_next;
                phase_reg     <= phase_next;
                since_reg     <= since_next;
                first_off_reg <= first_off_next;
                fill_reg      <= fill_next;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (advance && emit) begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

endmodule

// ===== rtl/tpss_match.sv =====
`timescale 1ns / 1ps

// Right-aligned compare of one pattern against the byte window.
// window byte d is the byte d positions back from the current one.
module tpss_match #(
    parameter int MAX_PATTERN = 8,
    parameter int LEN_W       = 4
) (
    input  logic [tpss_pkg::PATTERN_W-1:0] pattern,
    input  logic [LEN_W-1:0]               len,
    input  logic [8*MAX_PATTERN-1:0]       window,
    input  logic                           exact,
    output logic                           hit
);

    logic [MAX_PATTERN-1:0] ok;

    always_comb begin
        logic [LEN_W-1:0] d;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            d = len - LEN_W'(i + 1);
            if (LEN_W'(i) < len) begin
                ok[i] = tpss_pkg::fold(pattern[8*i +: 8], exact) ==
                        tpss_pkg::fold(window[8*d +: 8], exact);
            end else begin
                ok[i] = 1'b1;
            end
        end
    end

    assign hit = &ok;

endmodule

// ===== rtl/tpss_checker.sv =====
`timescale 1ns / 1ps
`include "two_pattern_stream_search_top_macros.svh"

module tpss_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input tpss_pkg::out_item_t             m_data
);

    logic no_first;
    logic no_second;
    logic first_rest_clear;
    logic second_clear;

    assign no_first         = m_valid && !m_data.first_found;
    assign no_second        = m_valid && !m_data.second_found;
    assign first_rest_clear = (m_data.first_offset == 32'd0) && !m_data.second_found;
    assign second_clear     = (m_data.second_offset == 32'd0);

    `TPSS_ASSERT_NEXT(a_out_valid_held, aclk, aresetn, m_valid && !m_ready, m_valid)
    `TPSS_ASSERT_NEXT(a_out_data_held, aclk, aresetn, m_valid && !m_ready, $stable(m_data))
    `TPSS_ASSERT_NOW(a_no_first_no_rest, aclk, aresetn, no_first, first_rest_clear)
    `TPSS_ASSERT_NOW(a_no_second_zero, aclk, aresetn, no_second, second_clear)

endmodule

bind two_pattern_stream_search_top tpss_checker u_tpss_checker (.*);

// ===== tb/two_pattern_stream_search_top_tb.sv =====
`timescale 1ns / 1ps

module two_pattern_stream_search_top_tb;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int DRAIN_CYCLES = 8;      // drain margin after the last owed result
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off for the backpressure test
    localparam int WIN_DEPTH    = 7;      // bytes kept behind the current one

    // search phases of the predictor
    typedef enum logic [1:0] {
        SEEK_FIRST,
        SEEK_SECOND,
        SEARCH_DONE
    } search_phase_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [tpss_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tpss_pkg::CFG_DATA_W-1:0] cfg_wr_data;
    logic                            s_valid;
    logic                            s_ready;
    tpss_pkg::in_item_t              s_data;
    logic                            m_valid;
    logic                            m_ready;
    tpss_pkg::out_item_t             m_data;

    two_pattern_stream_search_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // ------------------------------------------------------------------
    // Search predictor: register copies and search state
    // ------------------------------------------------------------------
    logic                 cfg_exact;
    logic [31:0]          cfg_base;
    logic [63:0]          cfg_pat1;
    logic [3:0]           cfg_len1;
    logic [63:0]          cfg_pat2;
    logic [3:0]           cfg_len2;

    logic [7:0]           hist [WIN_DEPTH];   // hist[0] is the previous byte
    logic [31:0]          stream_pos;
    search_phase_t        phase;
    logic [3:0]           since_first;
    logic [31:0]          first_off;
    logic [3:0]           hist_fill;

    // results still owed by the block, oldest first
    tpss_pkg::out_item_t  expected_results[$];
    tpss_pkg::out_item_t  want;

    // run bookkeeping
    int                   n_errors;
    int                   n_bytes;
    int                   n_streams;
    int                   n_results;
    int                   n_settings;
    int                   cycle_cnt;

    // idling controls
    bit                   tx_gaps_on;
    bit                   rx_stalls_on;
    bit                   hold_off_req;
    int                   stall_left;
    int                   hold_left;

    // ------------------------------------------------------------------
    // Clock, cycle counter, watchdog
    // ------------------------------------------------------------------
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial cycle_cnt = 0;
    always @(posedge aclk) cycle_cnt <= cycle_cnt + 1;

    // Hard stop if the run hangs (handshake never completes, result never shows).
    initial begin
        while (cycle_cnt < LIMIT_CYCLES) @(posedge aclk);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor helpers
    // ------------------------------------------------------------------

    // Effective pattern length: below min_len acts as min_len, above 8 acts as 8.
    function automatic int eff_len(input logic [3:0] len, input int min_len);
        if (int'(len) < min_len) return min_len;
        if (int'(len) > 8) return 8;
        return int'(len);
    endfunction

    // ASCII a..z to A..Z when folding is selected
    function automatic logic [7:0] case_fold(input logic [7:0] c, input logic exact);
        if (!exact && c >= 8'h61 && c <= 8'h7A) return c - 8'h20;
        return c;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        logic [7:0] l;
        l = c | 8'h20;
        return (l >= 8'h61 && l <= 8'h7A);
    endfunction

    // Pattern byte i lines up with the byte len-1-i back from the current one.
    function automatic bit window_hit(input logic [63:0] pat, input int len,
                                      input logic [7:0] cur);
        int         back;
        logic [7:0] w;
        for (int i = 0; i < len; i++) begin
            back = len - 1 - i;
            w = (back == 0) ? cur : hist[back-1];
            if (case_fold(pat[8*i +: 8], cfg_exact) != case_fold(w, cfg_exact)) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic rearm_search();
        for (int i = 0; i < WIN_DEPTH; i++) hist[i] = 8'h00;
        stream_pos  = '0;
        phase       = SEEK_FIRST;
        since_first = '0;
        first_off   = '0;
        hist_fill   = '0;
    endtask

    task automatic reset_search_model();
        cfg_exact = 1'b1;
        cfg_base  = '0;
        cfg_pat1  = '0;
        cfg_len1  = 4'd1;
        cfg_pat2  = '0;
        cfg_len2  = 4'd1;
        rearm_search();
    endtask

    // Advance the search by one accepted byte; has_res tells whether a result is owed.
    task automatic search_byte(input logic [7:0] b, input logic last,
                               output bit has_res, output tpss_pkg::out_item_t res);
        int          l1;
        int          l2;
        bit          emit;
        bit          hit2;
        logic [31:0] at2;
        emit = 1'b0;
        hit2 = 1'b0;
        at2  = '0;
        res  = '0;
        if (phase == SEEK_FIRST) begin
            l1 = eff_len(cfg_len1, 1);
            if (int'(hist_fill) + 1 >= l1 && window_hit(cfg_pat1, l1, b)) begin
                first_off   = cfg_base + stream_pos - 32'(l1 - 1);
                since_first = '0;
                if (eff_len(cfg_len2, 0) == 0) begin
                    emit  = 1'b1;
                    phase = SEARCH_DONE;
                end else begin
                    phase = SEEK_SECOND;
                end
            end
        end else if (phase == SEEK_SECOND) begin
            l2 = eff_len(cfg_len2, 0);
            if (since_first < tpss_pkg::SINCE_MAX) since_first++;
            if (l2 == 0) begin
                // second pattern cleared while it was sought
                emit  = 1'b1;
                phase = SEARCH_DONE;
            end else if (int'(since_first) >= l2 && window_hit(cfg_pat2, l2, b)) begin
                hit2  = 1'b1;
                at2   = cfg_base + stream_pos - 32'(l2 - 1);
                emit  = 1'b1;
                phase = SEARCH_DONE;
            end
        end

        // dropped bytes after an early finish do not advance the window
        if (phase != SEARCH_DONE || emit) begin
            for (int i = WIN_DEPTH - 1; i > 0; i--) hist[i] = hist[i-1];
            hist[0] = b;
            if (hist_fill < 4'(WIN_DEPTH)) hist_fill++;
            stream_pos++;
        end

        if (last && phase != SEARCH_DONE) emit = 1'b1;

        if (emit) begin
            res.first_found   = (phase == SEEK_SECOND || phase == SEARCH_DONE);
            res.first_offset  = res.first_found ? first_off : '0;
            res.second_found  = hit2;
            res.second_offset = hit2 ? at2 : '0;
            phase = SEARCH_DONE;
        end

        if (last) rearm_search();
        has_res = emit;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly back-to-back, sometimes a short gap, now and then a long one.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one byte, hold it until taken, then book the expected result.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int                  gap;
        bit                  has_res;
        tpss_pkg::out_item_t res;
        tpss_pkg::in_item_t  item;
        gap = tx_gaps_on ? pick_idle() : 0;
        item.data_byte = b;
        item.last_byte = last;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (s_ready !== 1'b1);
        search_byte(b, last, has_res, res);
        if (has_res) expected_results.push_back(res);
        n_bytes++;
        if (last) n_streams++;
    endtask

    // Stop offering, collect every owed result, let the pipe run dry.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [tpss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            tpss_pkg::CFG_EXACT_CMP:      cfg_exact = value[0];
            tpss_pkg::CFG_BASE_OFFSET:    cfg_base  = value[31:0];
            tpss_pkg::CFG_FIRST_PATTERN:  cfg_pat1  = value;
            tpss_pkg::CFG_FIRST_LENGTH:   cfg_len1  = value[3:0];
            tpss_pkg::CFG_SECOND_PATTERN: cfg_pat2  = value;
            tpss_pkg::CFG_SECOND_LENGTH:  cfg_len2  = value[3:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(input logic exact, input logic [31:0] base,
                                input logic [63:0] p1, input logic [3:0] l1,
                                input logic [63:0] p2, input logic [3:0] l2);
        write_reg(tpss_pkg::CFG_EXACT_CMP, {63'd0, exact});
        write_reg(tpss_pkg::CFG_BASE_OFFSET, {32'd0, base});
        write_reg(tpss_pkg::CFG_FIRST_PATTERN, p1);
        write_reg(tpss_pkg::CFG_FIRST_LENGTH, {60'd0, l1});
        write_reg(tpss_pkg::CFG_SECOND_PATTERN, p2);
        write_reg(tpss_pkg::CFG_SECOND_LENGTH, {60'd0, l2});
        n_settings++;
    endtask

    task automatic send_stream(input logic [7:0] bytes[$]);
        for (int i = 0; i < bytes.size(); i++) send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // Small alphabet so random streams actually hit the patterns.
    function automatic logic [7:0] alpha_byte();
        logic [7:0] c;
        c = 8'h41 + 8'($urandom_range(0, 3));
        if ($urandom_range(0, 1)) c = c | 8'h20;
        return c;
    endfunction

    function automatic logic [63:0] rand_pattern(input bit full_range);
        logic [63:0] p;
        for (int i = 0; i < 8; i++)
            p[8*i +: 8] = full_range ? 8'($urandom_range(0, 255)) : alpha_byte();
        return p;
    endfunction

    function automatic logic [3:0] rand_len(input int min_len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 4'd0;
        if (r < 16) return 4'($urandom_range(9, 15));
        return 4'($urandom_range((min_len > 0) ? min_len : 1, 8));
    endfunction

    function automatic logic [7:0] filler_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            if ($urandom_range(0, 1)) return cfg_pat1[8*$urandom_range(0, 7) +: 8];
            return cfg_pat2[8*$urandom_range(0, 7) +: 8];
        end
        if (r < 85) return alpha_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_filler(inout logic [7:0] q[$], input int max_n);
        int n;
        n = $urandom_range(0, max_n);
        repeat (n) q.push_back(filler_byte());
    endtask

    // Pattern bytes as they may appear in the stream: case flipped when folding.
    task automatic add_pattern(inout logic [7:0] q[$], input logic [63:0] pat, input int n);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            c = pat[8*i +: 8];
            if (!cfg_exact && is_letter(c) && $urandom_range(0, 1)) c = c ^ 8'h20;
            q.push_back(c);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls plus an on-demand long hold-off
    // ------------------------------------------------------------------
    initial begin
        m_ready    = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
                stall_left = pick_idle();
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                $error("result item with no expectation pending: %p", m_data);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                n_results++;
                if (m_data.first_found !== want.first_found) begin
                    $error("first_found: expected %0d, got %0d",
                           want.first_found, m_data.first_found);
                    n_errors++;
                end
                if (m_data.first_offset !== want.first_offset) begin
                    $error("first_offset: expected %08h, got %08h",
                           want.first_offset, m_data.first_offset);
                    n_errors++;
                end
                if (m_data.second_found !== want.second_found) begin
                    $error("second_found: expected %0d, got %0d",
                           want.second_found, m_data.second_found);
                    n_errors++;
                end
                if (m_data.second_offset !== want.second_offset) begin
                    $error("second_offset: expected %08h, got %08h",
                           want.second_offset, m_data.second_offset);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers: exact compare, both patterns a single zero byte, base 0.
    task automatic test_reset_defaults();
        send_stream('{8'h00, 8'h00});   // first at 0, second at 1, on the last byte
        send_stream('{8'h5A});          // no match at all
        settle();
    endtask

    // Offsets wrap at 32 bits; bytes after the second hit are dropped until last.
    task automatic test_wrap_and_drop();
        load_setting(1'b1, 32'hFFFF_FFFE, 64'h4241, 4'd2, 64'h4443, 4'd2);
        send_stream('{8'h78, 8'h41, 8'h42, 8'h43, 8'h44, 8'h7A, 8'h71});
        settle();
    endtask

    // Folded compare; bytes just outside a..z must not fold. Empty second pattern.
    task automatic test_case_fold();
        load_setting(1'b0, 32'd0, 64'h6261, 4'd2, 64'd0, 4'd0);
        send_stream('{8'h60, 8'h41, 8'h62, 8'h7B});
        settle();
    endtask

    // First length 0 acts as 1; result on the matching byte, which is also last.
    task automatic test_zero_first_length();
        load_setting(1'b1, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 64'd0, 4'd0);
        send_stream('{8'hFF});
        settle();
    endtask

    // Clearing the second length mid-search ends the search on the next byte.
    task automatic test_second_cleared();
        load_setting(1'b1, 32'd5, 64'h4241, 4'd2, 64'h5A5A, 4'd2);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        settle();                       // no result owed; pipe drained before the write
        write_reg(tpss_pkg::CFG_SECOND_LENGTH, 64'd0);
        send_byte(8'h78, 1'b0);
        send_byte(8'h79, 1'b1);
        settle();
    endtask

    // Zero pattern must not match the zeroed window before enough bytes are seen.
    task automatic test_short_window();
        load_setting(1'b1, 32'd0, 64'd0, 4'd4, 64'h41, 4'd1);
        send_stream('{8'h00, 8'h00, 8'h00});
        settle();
    endtask

    // Receiver holds off for a long stretch while single-byte streams keep coming,
    // each one owing a result, so the output backs up and input stalls.
    task automatic test_backpressure();
        load_setting(1'b1, 32'h1234_5678, 64'h51, 4'd1, 64'h52, 4'd1);
        tx_gaps_on   = 1'b0;
        hold_off_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_byte(($urandom_range(0, 1)) ? 8'h51 : 8'($urandom_range(0, 255)), 1'b1);
        settle();
        tx_gaps_on = 1'b1;
    endtask

    // Random phases, each with its own register setting; mostly well-formed streams
    // (filler, first pattern, filler, second pattern), some broken, some pure noise.
    task automatic test_random_streams();
        logic [7:0]  sq[$];
        logic [63:0] p1;
        logic [63:0] p2;
        int          sent;
        int          kind;
        for (int ph = 0; ph < 10; ph++) begin
            tx_gaps_on   = (ph % 3 != 1);
            rx_stalls_on = (ph % 3 != 1);
            case (ph)
                0: load_setting(1'b1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8,
                                rand_pattern(1'b1), 4'd8);
                1: load_setting(1'b0, 32'd0, rand_pattern(1'b0), 4'd1, 64'd0, 4'd0);
                2: load_setting(1'b0, $urandom, rand_pattern(1'b0), 4'd15,
                                rand_pattern(1'b0), 4'd15);
                3: load_setting(1'b1, $urandom, rand_pattern(1'b1), 4'd9,
                                rand_pattern(1'b1), 4'd1);
                default: begin
                    p1 = rand_pattern($urandom_range(0, 3) == 0);
                    p2 = rand_pattern($urandom_range(0, 3) == 0);
                    load_setting(1'($urandom_range(0, 1)), $urandom, p1, rand_len(1),
                                 p2, rand_len(0));
                end
            endcase
            sent = 0;
            while (sent < 115) begin
                sq.delete();
                kind = $urandom_range(0, 99);
                if (kind < 75) begin
                    add_filler(sq, 5);
                    add_pattern(sq, cfg_pat1, eff_len(cfg_len1, 1));
                    add_filler(sq, 5);
                    add_pattern(sq, cfg_pat2, eff_len(cfg_len2, 0));
                    add_filler(sq, 3);
                end else if (kind < 90) begin
                    // broken: a truncated first or second pattern
                    add_filler(sq, 4);
                    if ($urandom_range(0, 1)) begin
                        add_pattern(sq, cfg_pat1, eff_len(cfg_len1, 1));
                        add_filler(sq, 2);
                        add_pattern(sq, cfg_pat2, $urandom_range(0, eff_len(cfg_len2, 0)));
                    end else begin
                        add_pattern(sq, cfg_pat1, $urandom_range(0, eff_len(cfg_len1, 1)));
                    end
                end else begin
                    repeat ($urandom_range(1, 12)) sq.push_back(8'($urandom_range(0, 255)));
                end
                if (sq.size() == 0) sq.push_back(filler_byte());
                send_stream(sq);
                sent += sq.size();
            end
            settle();
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_data       = '0;
        n_errors     = 0;
        n_bytes      = 0;
        n_streams    = 0;
        n_results    = 0;
        n_settings   = 0;
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        hold_off_req = 1'b0;
        reset_search_model();

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_wrap_and_drop();
        test_case_fold();
        test_zero_first_length();
        test_second_cleared();
        test_short_window();
        test_backpressure();
        test_random_streams();
        settle();

        $display("Streamed %0d bytes in %0d streams under %0d register settings,",
                 n_bytes, n_streams, n_settings);
        $display("checked %0d result items with random gaps, stalls and one long hold-off.",
                 n_results);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tpss_pkg.sv
rtl/tpss_match.sv
rtl/two_pattern_stream_search_top.sv
rtl/tpss_checker.sv
tb/two_pattern_stream_search_top_tb.sv
